@@ src/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on the next clock edge
`define CHK_NEXT(lbl, cond, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) else $error(msg);

// implication checked on the same clock edge
`define CHK_NOW(lbl, cond, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) else $error(msg);

`endif

@@ src/foc_pkg.sv @@
`timescale 1ns / 1ps
package foc_pkg;

   localparam int SINE_TABLE_DEPTH = 1024;
   localparam int ANGLE_BITS       = 16;
   localparam int SIN_IDX_BITS     = $clog2(SINE_TABLE_DEPTH);
   localparam int CSR_IDX_BITS     = 3;
   localparam int CSR_DATA_BITS    = 32;
   localparam logic [32:0] INV_SQRT3_Q16 = 33'd37837;

   localparam logic [CSR_IDX_BITS-1:0] CSR_KP_D    = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_KI_TS_D = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LIMIT_D = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_KP_Q    = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_KI_TS_Q = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LIMIT_Q = 3'd5;

   localparam logic [23:0] KP_D_RESET    = 24'd6554;
   localparam logic [31:0] KI_TS_D_RESET = 32'd4295;
   localparam logic [14:0] LIMIT_D_RESET = 15'd16384;
   localparam logic [23:0] KP_Q_RESET    = 24'd52429;
   localparam logic [31:0] KI_TS_Q_RESET = 32'd43;
   localparam logic [14:0] LIMIT_Q_RESET = 15'd4096;

   typedef struct packed {
      logic signed [15:0] current_a;
      logic signed [15:0] current_b;
      logic [15:0]        elec_angle;
      logic signed [15:0] target_d;
      logic signed [15:0] target_q;
   } req_payload_type;

   typedef struct packed {
      logic signed [15:0] volt_alpha;
      logic signed [15:0] volt_beta;
      logic signed [15:0] meas_d;
      logic signed [15:0] meas_q;
      logic signed [15:0] drive_d;
      logic signed [15:0] drive_q;
   } rsp_payload_type;

   typedef enum logic [4:0] {
      S_SIN, S_COS,
      S_M0, S_M1, S_M2, S_M3, S_M4, S_M5,
      S_P0, S_P1, S_P2, S_P3,
      S_V0, S_V1, S_V2, S_V3, S_V4
   } step_type;

   typedef struct packed {
      logic     capture;
      logic     run;
      step_type step;
      logic     publish;
   } cmd_type;

   typedef logic signed [15:0] sin_tab_type [SINE_TABLE_DEPTH];
   typedef logic [63:0] coef_tab_type [6];

   localparam coef_tab_type POLY_COEF = '{
      64'd1686629713, 64'd693598668, 64'd85569306, 64'd5026995, 64'd172272, 64'd3864
   };

   // quarter-wave odd polynomial, mirrored and negated per quadrant
   function automatic sin_tab_type build_sin_tab();
      sin_tab_type t;
      logic [63:0] pos, quad, rem, z, z2, p;
      logic [15:0] v;
      for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
         pos  = 64'(k) * 64'd4;
         quad = pos / SINE_TABLE_DEPTH;
         rem  = pos % SINE_TABLE_DEPTH;
         z    = (rem << 30) / SINE_TABLE_DEPTH;
         if (quad[0]) begin
            z = (64'd1 << 30) - z;
         end
         z2 = (z * z) >> 30;
         p  = POLY_COEF[5];
         for (int i = 4; i >= 0; i--) begin
            p = POLY_COEF[i] - ((p * z2) >> 30);
         end
         p = (p * z) >> 30;
         v = 16'((p + 64'd32768) >> 16);
         t[k] = quad[1] ? -$signed(v) : $signed(v);
      end
      return t;
   endfunction

   localparam sin_tab_type SIN_TAB = build_sin_tab();

   function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
      if (v > 64'sd32767) begin
         return 16'sh7fff;
      end
      if (v < -64'sd32768) begin
         return 16'sh8000;
      end
      return 16'(v);
   endfunction

   // round half up then arithmetic shift
   function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                     input int unsigned s);
      logic signed [63:0] t;
      t = v + (64'sd1 <<< (s - 1));
      return t >>> s;
   endfunction

   function automatic logic signed [63:0] clampsym(input logic signed [63:0] v,
                                                    input logic signed [63:0] lim);
      if (v > lim) begin
         return lim;
      end
      if (v < -lim) begin
         return -lim;
      end
      return v;
   endfunction

endpackage

@@ src/foc_req_if.sv @@
`timescale 1ns / 1ps
interface foc_req_if;
   import foc_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ src/foc_rsp_if.sv @@
`timescale 1ns / 1ps
interface foc_rsp_if;
   import foc_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ src/foc_ctrl.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module foc_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output foc_pkg::cmd_type cmd
);
   import foc_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FINISH} state_type;

   state_type state_ff, state_in;
   step_type  step_ff, step_in;
   logic      out_valid_ff, out_valid_in;
   logic      accept, publish;

   assign accept  = req_valid && (state_ff == ST_IDLE);
   assign publish = (state_ff == ST_FINISH) && (!out_valid_ff || rsp_ready);

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      out_valid_in = out_valid_ff;
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_RUN;
               step_in  = S_SIN;
            end
         end
         ST_RUN: begin
            if (step_ff == S_V4) begin
               state_in = ST_FINISH;
            end else begin
               step_in = step_type'(step_ff + 5'd1);
            end
         end
         ST_FINISH: begin
            if (publish) begin
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= S_SIN;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = out_valid_ff;
   assign cmd.capture = accept;
   assign cmd.run     = (state_ff == ST_RUN);
   assign cmd.step    = step_ff;
   assign cmd.publish = publish;

   `CHK_NEXT(a_start, accept, (state_ff == ST_RUN) && (step_ff == S_SIN), "request did not start")
   `CHK_NEXT(a_last, (state_ff == ST_RUN) && (step_ff == S_V4), state_ff == ST_FINISH, "no finish")
   `CHK_NOW(a_pub, publish, !out_valid_ff || rsp_ready, "result overwritten")

endmodule

@@ src/foc_datapath.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module foc_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  foc_pkg::cmd_type                    cmd,
   input  foc_pkg::req_payload_type            req_data,
   output foc_pkg::rsp_payload_type            rsp_data,
   input  logic                                csr_we,
   input  logic [foc_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [foc_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import foc_pkg::*;

   logic [23:0] kp_d_ff, kp_q_ff;
   logic [31:0] ki_ts_d_ff, ki_ts_q_ff;
   logic [14:0] limit_d_ff, limit_q_ff;

   logic signed [15:0] ia_ff, ib_ff, td_ff, tq_ff;
   logic [SIN_IDX_BITS-1:0] idx_ff;
   logic signed [15:0] sn_ff, cs_ff, beta_ff, md_ff, mq_ff, ed_ff, eq_ff;
   logic signed [15:0] dd_ff, dq_ff, va_ff, vb_ff;
   logic signed [47:0] integ_d_ff, integ_q_ff;
   logic signed [33:0] acc_ff;
   logic signed [50:0] prod_ff;
   rsp_payload_type    out_ff;

   logic signed [17:0] mul_a;
   logic signed [32:0] mul_b;
   logic signed [63:0] prod_w, acc_w, bound_d, bound_q;
   logic [SIN_IDX_BITS-1:0] cos_idx;

   assign prod_w  = 64'(prod_ff);
   assign acc_w   = 64'(acc_ff);
   assign bound_d = $signed({17'd0, limit_d_ff, 32'd0});
   assign bound_q = $signed({17'd0, limit_q_ff, 32'd0});
   assign cos_idx = idx_ff + SIN_IDX_BITS'(SINE_TABLE_DEPTH / 4);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.step)
         S_SIN: begin
            mul_a = 18'(ia_ff) + (18'(ib_ff) <<< 1);
            mul_b = $signed(INV_SQRT3_Q16);
         end
         S_M0: begin mul_a = 18'(ia_ff);   mul_b = 33'(cs_ff); end
         S_M1: begin mul_a = 18'(beta_ff); mul_b = 33'(sn_ff); end
         S_M2: begin mul_a = 18'(beta_ff); mul_b = 33'(cs_ff); end
         S_M3: begin mul_a = 18'(ia_ff);   mul_b = 33'(sn_ff); end
         S_M5: begin mul_a = 18'(ed_ff);   mul_b = $signed({1'b0, ki_ts_d_ff}); end
         S_P0: begin mul_a = 18'(ed_ff);   mul_b = $signed({9'd0, kp_d_ff}); end
         S_P1: begin mul_a = 18'(eq_ff);   mul_b = $signed({1'b0, ki_ts_q_ff}); end
         S_P2: begin mul_a = 18'(eq_ff);   mul_b = $signed({9'd0, kp_q_ff}); end
         S_V0: begin mul_a = 18'(dd_ff);   mul_b = 33'(cs_ff); end
         S_V1: begin mul_a = 18'(dq_ff);   mul_b = 33'(sn_ff); end
         S_V2: begin mul_a = 18'(dd_ff);   mul_b = 33'(sn_ff); end
         S_V3: begin mul_a = 18'(dq_ff);   mul_b = 33'(cs_ff); end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_d_ff    <= KP_D_RESET;
         ki_ts_d_ff <= KI_TS_D_RESET;
         limit_d_ff <= LIMIT_D_RESET;
         kp_q_ff    <= KP_Q_RESET;
         ki_ts_q_ff <= KI_TS_Q_RESET;
         limit_q_ff <= LIMIT_Q_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_KP_D:    kp_d_ff    <= csr_wdata[23:0];
            CSR_KI_TS_D: ki_ts_d_ff <= csr_wdata;
            CSR_LIMIT_D: limit_d_ff <= csr_wdata[14:0];
            CSR_KP_Q:    kp_q_ff    <= csr_wdata[23:0];
            CSR_KI_TS_Q: ki_ts_q_ff <= csr_wdata;
            CSR_LIMIT_Q: limit_q_ff <= csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_d_ff <= '0;
         integ_q_ff <= '0;
      end else if (cmd.run) begin
         case (cmd.step)
            S_P0: integ_d_ff <= 48'(clampsym(64'(integ_d_ff) + prod_w, bound_d));
            S_P2: integ_q_ff <= 48'(clampsym(64'(integ_q_ff) + prod_w, bound_q));
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         ia_ff  <= req_data.current_a;
         ib_ff  <= req_data.current_b;
         td_ff  <= req_data.target_d;
         tq_ff  <= req_data.target_q;
         idx_ff <= req_data.elec_angle[ANGLE_BITS-1 -: SIN_IDX_BITS];
      end
      if (cmd.publish) begin
         out_ff <= '{volt_alpha: va_ff, volt_beta: vb_ff, meas_d: md_ff, meas_q: mq_ff,
                     drive_d: dd_ff, drive_q: dq_ff};
      end
      if (cmd.run) begin
         prod_ff <= 51'(mul_a * mul_b);
         case (cmd.step)
            S_SIN: sn_ff <= SIN_TAB[idx_ff];
            S_COS: begin
               cs_ff   <= SIN_TAB[cos_idx];
               beta_ff <= sat16(rnd_shift(prod_w, 16));
            end
            S_M1: acc_ff <= 34'(prod_ff);
            S_M2: md_ff  <= sat16(rnd_shift(acc_w + prod_w, 14));
            S_M3: acc_ff <= 34'(prod_ff);
            S_M4: begin
               mq_ff <= sat16(rnd_shift(acc_w - prod_w, 14));
               ed_ff <= sat16(64'(td_ff) - 64'(md_ff));
            end
            S_M5: eq_ff <= sat16(64'(tq_ff) - 64'(mq_ff));
            S_P1: dd_ff <= 16'(rnd_shift(clampsym((prod_w <<< 16) + 64'(integ_d_ff),
                                                  bound_d), 32));
            S_P3: dq_ff <= 16'(rnd_shift(clampsym((prod_w <<< 16) + 64'(integ_q_ff),
                                                  bound_q), 32));
            S_V1: acc_ff <= 34'(prod_ff);
            S_V2: va_ff  <= sat16(rnd_shift(acc_w - prod_w, 14));
            S_V3: acc_ff <= 34'(prod_ff);
            S_V4: vb_ff  <= sat16(rnd_shift(acc_w + prod_w, 14));
            default: ;
         endcase
      end
   end

   assign rsp_data = out_ff;

   `CHK_NEXT(a_integ_d, cmd.run && (cmd.step == S_P0), (64'(integ_d_ff) <= $past(bound_d)) && (64'(integ_d_ff) >= -$past(bound_d)), "d integrator out of bound")
   `CHK_NEXT(a_integ_q, cmd.run && (cmd.step == S_P2), (64'(integ_q_ff) <= $past(bound_q)) && (64'(integ_q_ff) >= -$past(bound_q)), "q integrator out of bound")

endmodule

@@ src/foc_current_loop_unit.sv @@
`timescale 1ns / 1ps
// current loop of a field-oriented motor drive: Clarke, Park, two PI
// regulators with clamped integrators, inverse Park
// request channel req_bus carries phase currents, electrical angle and
// d/q current targets; response channel rsp_bus carries alpha/beta voltage
// commands, measured d/q currents and the two PI outputs
// csr_we/csr_index/csr_wdata write gains and limits, only while idle; the user
// must keep to this, as the block itself does not enforce it
// one request at a time: a request is taken only while the unit is idle, then
// 17 steps run through one shared 18x33 multiplier and a sine table; the unit
// turns idle again, ready for the next request, once the response is published
// the response sits in an output register; if the receiver stalls, the
// next request is still computed and waits after its last step until the
// output register is free
// reset (synchronous) clears both integrators, restores the default
// gains and limits and empties the output register
module foc_current_loop_unit (
   input  logic                              clock,
   input  logic                              reset,
   foc_req_if.sink                           req_bus,
   foc_rsp_if.source                         rsp_bus,
   input  logic                              csr_we,
   input  logic [foc_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [foc_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import foc_pkg::*;

   cmd_type cmd;

   foc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd)
   );

   foc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_bus.data),
      .rsp_data  (rsp_bus.data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
   import foc_pkg::*;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   foc_req_if req_bus ();
   foc_rsp_if rsp_bus ();

   foc_current_loop_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus.sink),
      .rsp_bus   (rsp_bus.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   req_payload_type pending_req [$];
   rsp_payload_type expected_rsp [$];
   int errors = 0;
   int rsp_count = 0;

   logic [23:0] gain_p_d, gain_p_q;
   logic [31:0] gain_i_d, gain_i_q;
   logic [14:0] clamp_d, clamp_q;
   longint integ_d, integ_q;
   longint sine_lut [SINE_TABLE_DEPTH];

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("foc_current_loop_unit test failed");
      $finish;
   end

   // quarter-wave odd polynomial in Q30, folded into a full-turn table
   function automatic void fill_sine_lut();
      longint unsigned coef [6];
      longint unsigned pos, quad, rem, z, z2, p;
      longint v;
      coef = '{64'd1686629713, 64'd693598668, 64'd85569306, 64'd5026995,
               64'd172272, 64'd3864};
      for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
         pos = longint'(k) * 4;
         quad = pos / SINE_TABLE_DEPTH;
         rem = pos % SINE_TABLE_DEPTH;
         z = (rem << 30) / SINE_TABLE_DEPTH;
         if (quad[0]) begin
            z = (64'd1 << 30) - z;
         end
         z2 = (z * z) >> 30;
         p = coef[5];
         for (int i = 4; i >= 0; i--) begin
            p = coef[i] - ((p * z2) >> 30);
         end
         p = (p * z) >> 30;
         v = longint'((p + 32768) >> 16);
         sine_lut[k] = quad[1] ? -v : v;
      end
   endfunction

   function automatic longint round_down(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic longint clip16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic longint clip_sym(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   function automatic longint regulate(longint err, longint kp, longint ki, longint lim,
                                       inout longint integ);
      longint bound;
      bound = lim <<< 32;
      integ = clip_sym(integ + err * ki, bound);
      return round_down(clip_sym(err * kp * 65536 + integ, bound), 32);
   endfunction

   function automatic rsp_payload_type current_loop_step(req_payload_type r);
      rsp_payload_type o;
      longint a, b, sn, cs, md, mq, dd, dq;
      logic [15:0] cos_ang;
      a = r.current_a;
      b = clip16(round_down((longint'(r.current_a) + 2 * longint'(r.current_b)) * 37837, 16));
      cos_ang = r.elec_angle + 16'd16384;
      sn = sine_lut[r.elec_angle[15:6]];
      cs = sine_lut[cos_ang[15:6]];
      md = clip16(round_down(a * cs + b * sn, 14));
      mq = clip16(round_down(b * cs - a * sn, 14));
      dd = regulate(clip16(longint'(r.target_d) - md), gain_p_d, gain_i_d, clamp_d, integ_d);
      dq = regulate(clip16(longint'(r.target_q) - mq), gain_p_q, gain_i_q, clamp_q, integ_q);
      o.volt_alpha = 16'(clip16(round_down(dd * cs - dq * sn, 14)));
      o.volt_beta = 16'(clip16(round_down(dd * sn + dq * cs, 14)));
      o.meas_d = 16'(md);
      o.meas_q = 16'(mq);
      o.drive_d = 16'(dd);
      o.drive_q = 16'(dq);
      return o;
   endfunction

   // request driver: bursts with random gaps
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.data <= '0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_rsp.push_back(current_loop_step(req_bus.data));
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_bus.valid <= 1'b0;
            end else if (pending_req.size() > 0) begin
               req_bus.data <= pending_req.pop_front();
               req_bus.valid <= 1'b1;
               if (burst_left > 0) begin
                  burst_left <= burst_left - 1;
               end else begin
                  burst_left <= $urandom_range(0, 20);
                  gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
               end
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // response receiver: randomly chosen stall patterns, one long hold-off once 300 responses are in
   int ready_phase = 0;
   int ready_mode = 0;
   int long_hold = 0;
   bit long_done = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (long_hold > 0) begin
         long_hold <= long_hold - 1;
         rsp_bus.ready <= 1'b0;
      end else if (!long_done && rsp_count >= 300) begin
         long_done <= 1'b1;
         long_hold <= 400;
         rsp_bus.ready <= 1'b0;
      end else begin
         ready_phase <= ready_phase + 1;
         if (ready_phase % 64 == 0) begin
            ready_mode <= $urandom_range(0, 2);
         end
         case (ready_mode)
            0: rsp_bus.ready <= 1'b1;
            1: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
            default: rsp_bus.ready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   // response checker
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         rsp_count <= rsp_count + 1;
         if (expected_rsp.size() == 0) begin
            $display("%t unexpected response: expected none, actual %h", $realtime,
                     rsp_bus.data);
            errors++;
         end else begin
            want = expected_rsp.pop_front();
            for (int f = 0; f < 6; f++) begin
               if (want[95-16*f -: 16] !== rsp_bus.data[95-16*f -: 16]) begin
                  $display("%t field %0d mismatch: expected %0d, actual %0d", $realtime, f,
                           $signed(want[95-16*f -: 16]), $signed(rsp_bus.data[95-16*f -: 16]));
                  errors++;
               end
            end
         end
      end
   end

   task automatic write_reg(logic [CSR_IDX_BITS-1:0] idx, logic [31:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_KP_D:    gain_p_d = val[23:0];
         CSR_KI_TS_D: gain_i_d = val;
         CSR_LIMIT_D: clamp_d = val[14:0];
         CSR_KP_Q:    gain_p_q = val[23:0];
         CSR_KI_TS_Q: gain_i_q = val;
         CSR_LIMIT_Q: clamp_q = val[14:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_req.size() != 0 || req_bus.valid || expected_rsp.size() != 0) begin
         @(posedge clock);
      end
      repeat (40) @(posedge clock);
   endtask

   function automatic logic [15:0] pick16();
      case ($urandom_range(0, 5))
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return 16'($urandom_range(0, 65535));
         default: return 16'($signed($urandom_range(0, 4095)) - 2048);
      endcase
   endfunction

   function automatic req_payload_type random_request();
      req_payload_type r;
      r.current_a = pick16();
      r.current_b = pick16();
      r.elec_angle = 16'($urandom_range(0, 65535));
      r.target_d = pick16();
      r.target_q = pick16();
      return r;
   endfunction

   function automatic logic [31:0] random_gain();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 255);
         1: return $urandom_range(0, 65535);
         2: return $urandom_range(0, 1 << 20);
         default: return $urandom;
      endcase
   endfunction

   initial begin
      req_payload_type r;
      logic [15:0] extremes [4];
      extremes = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      gain_p_d = KP_D_RESET;
      gain_i_d = KI_TS_D_RESET;
      clamp_d = LIMIT_D_RESET;
      gain_p_q = KP_Q_RESET;
      gain_i_q = KI_TS_Q_RESET;
      clamp_q = LIMIT_Q_RESET;
      integ_d = 0;
      integ_q = 0;
      fill_sine_lut();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes and quadrant angles at reset gains
      for (int i = 0; i < 16; i++) begin
         r.current_a = extremes[i % 4];
         r.current_b = extremes[(i / 4) % 4];
         r.elec_angle = 16'(i * 16384 + i / 4);
         r.target_d = extremes[(i + 1) % 4];
         r.target_q = extremes[(i + 2) % 4];
         pending_req.push_back(r);
      end
      r = '{16'sd1024, 16'sd0, 16'hffff, 16'sd0, 16'sd0};
      pending_req.push_back(r);
      wait_idle();

      // full gains and limits, with wide data masked and out-of-range indexes
      write_reg(CSR_KP_D, 32'hffffffff);
      write_reg(CSR_KI_TS_D, 32'hffffffff);
      write_reg(CSR_LIMIT_D, 32'hffffffff);
      write_reg(CSR_KP_Q, 32'hffffffff);
      write_reg(CSR_KI_TS_Q, 32'hffffffff);
      write_reg(CSR_LIMIT_Q, 32'hffffffff);
      write_reg(3'd6, 32'd0);
      write_reg(3'd7, 32'd0);
      for (int i = 0; i < 4; i++) pending_req.push_back(random_request());
      wait_idle();

      // zero limits pin both regulators
      write_reg(CSR_LIMIT_D, 32'd0);
      write_reg(CSR_LIMIT_Q, 32'd0);
      for (int i = 0; i < 4; i++) pending_req.push_back(random_request());
      wait_idle();

      // zero gains
      write_reg(CSR_KP_D, 32'd0);
      write_reg(CSR_KI_TS_D, 32'd0);
      write_reg(CSR_LIMIT_D, 32'd32767);
      write_reg(CSR_KP_Q, 32'd0);
      write_reg(CSR_KI_TS_Q, 32'd0);
      write_reg(CSR_LIMIT_Q, 32'd1);
      for (int i = 0; i < 4; i++) pending_req.push_back(random_request());
      wait_idle();

      // random phases
      for (int ph = 0; ph < 8; ph++) begin
         write_reg(CSR_KP_D, random_gain());
         write_reg(CSR_KI_TS_D, random_gain());
         write_reg(CSR_LIMIT_D, $urandom_range(0, 32767));
         write_reg(CSR_KP_Q, random_gain());
         write_reg(CSR_KI_TS_Q, random_gain());
         write_reg(CSR_LIMIT_Q, $urandom_range(0, 32767));
         for (int i = 0; i < 100; i++) pending_req.push_back(random_request());
         wait_idle();
      end

      if (errors == 0) begin
         $display("foc_current_loop_unit test passed");
      end else begin
         $display("foc_current_loop_unit test failed");
      end
      $finish;
   end
endmodule
